FILE: src/swod_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed constants of the sliding window outlier detector.
// No dependencies; used by swod_stats and sliding_window_outlier_detector_core.
package swod_pkg;

  localparam int unsigned SAMPLE_W = 16;  // Q8.8 sample
  localparam int unsigned IDX_W    = 16;  // window position, wraps
  localparam int unsigned TH_W     = 8;   // threshold, unsigned Q4.4
  localparam int unsigned THSQ_W   = 2 * TH_W;
  localparam int unsigned LHS_SHIFT = 8;  // Q4.4 squared scale on the left-hand side

  localparam logic [TH_W-1:0] TH_RESET = 8'd32;  // 2.0

  // control from the sequencer to the statistics unit
  typedef struct packed {
    logic clr;     // start of a new window
    logic sum_en;  // add head sample to the window sum
    logic dev_en;  // head sample enters the deviation pipeline
  } swod_ctrl_t;

endpackage

FILE: src/sliding_window_outlier_detector_core.sv
`timescale 1ns / 1ps
// Sliding window z-score outlier detector, top level: cell chain, sequencer, threshold test.
// Depends on swod_pkg, swod_cell, swod_stats.
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------
//  s_axis   | in  | tdata: sample[15:0]; tuser: series_start
//  m_axis   | out | tdata: window_start[15:0]; tuser: anomaly
//  cfg      | in  | cfg_data_i: deviation_threshold (Q4.4), always ready
//
// A sample that only fills the window leaves the sequencer idle. A sample that completes a
// window starts a run: the chain rotates once for the sum and once through the
// deviation/square pipeline, then the split threshold product is formed in LIM0 and LIM1
// and the compare is made in DONE. The input is ready only when the sequencer is idle;
// a result waits in the output register, and the sequencer holds in its last step while
// that is full. Reset empties the window, zeroes the position and sets the threshold to 2.0.
module sliding_window_outlier_detector_core #(
  parameter int unsigned WINDOW = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic [0:0]  s_axis_tuser,   // [0] series_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] window_start
  output logic [0:0]  m_axis_tuser,   // [0] anomaly
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import swod_pkg::*;

  localparam int unsigned CW     = $clog2(WINDOW);
  localparam int unsigned NW     = $clog2(WINDOW + 1);
  localparam int unsigned DW     = 18 + CW;
  localparam int unsigned SQW    = 2 * DW - 2;
  localparam int unsigned SPW    = SQW + CW;
  localparam int unsigned LO_W   = (SPW + 1) / 2;
  localparam int unsigned HI_W   = SPW - LO_W;
  localparam int unsigned LW     = SPW + THSQ_W;
  localparam int unsigned LHW    = SQW + NW + LHS_SHIFT;
  localparam int unsigned FILL_W = (CW > 0) ? CW : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 2);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  CNT_N    = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0]  CNT_DEV  = CNT_W'(WINDOW + 1);
  localparam logic [NW-1:0]     N_U      = NW'(WINDOW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_DEV  = 3'd2;
  localparam logic [2:0] ST_LIM0 = 3'd3;
  localparam logic [2:0] ST_LIM1 = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [FILL_W-1:0]   fill_q, eff_fill;
  logic [IDX_W-1:0]    idx_q;
  logic [THSQ_W-1:0]   thsq_q;
  logic                in_acc, win_full, rotate, res_load, out_free;
  swod_ctrl_t          ctrl;
  logic [15:0]         cell_q [WINDOW];
  logic [15:0]         cell_d [WINDOW];
  logic [SPW-1:0]      spread;
  logic [SQW-1:0]      max_sq;
  logic [SQW+NW-1:0]   lprod;
  logic [LHW-1:0]      lhs_q;
  logic [THSQ_W+LO_W-1:0] plo_q;
  logic [THSQ_W+HI_W-1:0] phi;
  logic [LW-1:0]       limit_q, limit_d;
  logic                mvalid_q;

  // ---------------------------------------------------------------- cell chain
  // cell 0 is the oldest sample; the chain shifts toward it on load and on rotate
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == WINDOW - 1) begin : g_tail
      assign cell_d[i] = in_acc ? s_axis_tdata : cell_q[0];
    end else begin : g_body
      assign cell_d[i] = cell_q[i+1];
    end
    swod_cell u_cell (
      .clk_i (clk_i),
      .en_i  (in_acc | rotate),
      .d_i   (cell_d[i]),
      .q_o   (cell_q[i])
    );
  end

  swod_stats #(
    .WINDOW (WINDOW)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .head_i   (cell_q[0]),
    .spread_o (spread),
    .max_sq_o (max_sq)
  );

  // ---------------------------------------------------------------- sequencer
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign eff_fill      = s_axis_tuser[0] ? '0 : fill_q;
  assign win_full      = (eff_fill == FILL_MAX);
  assign out_free      = !mvalid_q || m_axis_tready;
  assign res_load      = (state_q == ST_DONE) && out_free;

  assign ctrl.clr    = in_acc & win_full;
  assign ctrl.sum_en = (state_q == ST_SUM);
  assign ctrl.dev_en = (state_q == ST_DEV) && (cnt_q < CNT_N);
  assign rotate      = ctrl.sum_en | ctrl.dev_en;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc && win_full) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_N - 1'b1) begin
          cnt_d   = '0;
          state_d = ST_DEV;
        end
      end
      ST_DEV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_DEV) begin
          cnt_d   = '0;
          state_d = ST_LIM0;
        end
      end
      ST_LIM0: state_d = ST_LIM1;
      ST_LIM1: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      fill_q  <= '0;
      idx_q   <= '0;
      thsq_q  <= THSQ_W'(TH_RESET) * THSQ_W'(TH_RESET);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (in_acc) begin
        fill_q <= win_full ? eff_fill : eff_fill + 1'b1;
        if (s_axis_tuser[0]) begin
          idx_q <= '0;
        end
      end
      if (res_load) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cfg_valid_i) begin
        thsq_q <= THSQ_W'(cfg_data_i) * THSQ_W'(cfg_data_i);
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- threshold test
  // th^2 * spread is split into a low partial product registered in LIM0 and a high one added in LIM1
  assign lprod   = max_sq * N_U;
  assign phi     = thsq_q * spread[SPW-1:LO_W];
  assign limit_d = {phi, {LO_W{1'b0}}} + {{HI_W{1'b0}}, plo_q};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LIM0) begin
      plo_q <= thsq_q * spread[LO_W-1:0];
      lhs_q <= {lprod, {LHS_SHIFT{1'b0}}};
    end
    if (state_q == ST_LIM1) begin
      limit_q <= limit_d;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
    end else if (res_load) begin
      mvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      mvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      m_axis_tuser[0] <= ({{(LW-LHW){1'b0}}, lhs_q} > limit_q);
      m_axis_tdata    <= idx_q;
    end
  end

  assign m_axis_tvalid = mvalid_q;

  // ---------------------------------------------------------------- assertions
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("fill count beyond window depth");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_DEV)
    else $error("sequence counter out of range");

  a_full_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && win_full) |=> (state_q == ST_SUM))
    else $error("completed window did not start processing");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (idx_q == IDX_W'($past(idx_q) + 1'b1)))
    else $error("window position did not advance with a result");

  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEV) |-> !in_acc)
    else $error("transaction accepted during deviation pass");

endmodule

FILE: src/swod_cell.sv
`timescale 1ns / 1ps
// One sample cell of the window chain: holds a sample, takes its neighbor's value when enabled.
// No dependencies.
module swod_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] d_i,
  output logic [15:0] q_o
);

  logic [15:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= d_i;
    end
  end

  assign q_o = sample_q;

endmodule

FILE: src/swod_stats.sv
`timescale 1ns / 1ps
// Window statistics: sum, deviation N*v-S, its square, spread and largest square.
// Depends on swod_pkg.
module swod_stats #(
  parameter int unsigned WINDOW = 3
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  swod_pkg::swod_ctrl_t                    ctrl_i,
  input  logic [15:0]                             head_i,
  output logic [2*(18+$clog2(WINDOW))-2+$clog2(WINDOW)-1:0] spread_o,
  output logic [2*(18+$clog2(WINDOW))-3:0]        max_sq_o
);
  import swod_pkg::*;

  localparam int unsigned CW    = $clog2(WINDOW);
  localparam int unsigned SUM_W = SAMPLE_W + CW;
  localparam int unsigned DW    = 18 + CW;
  localparam int unsigned SQW   = 2 * DW - 2;
  localparam int unsigned SPW   = SQW + CW;
  localparam logic signed [DW-1:0] N_S = DW'(WINDOW);

  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DW-1:0]     head_x, sum_x, dev_d, dev_q;
  logic signed [2*DW-1:0]   sq_full;
  logic [SQW-1:0]           sq_q, max_q;
  logic [SPW-1:0]           spread_q;
  logic                     dv1_q, dv2_q;

  assign head_x  = {{(DW-SAMPLE_W){head_i[SAMPLE_W-1]}}, head_i};
  assign sum_x   = {{(DW-SUM_W){sum_q[SUM_W-1]}}, sum_q};
  assign dev_d   = head_x * N_S - sum_x;
  assign sq_full = dev_q * dev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv1_q <= 1'b0;
      dv2_q <= 1'b0;
    end else begin
      dv1_q <= ctrl_i.dev_en;
      dv2_q <= dv1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      sum_q <= '0;
    end else if (ctrl_i.sum_en) begin
      sum_q <= sum_q + {{CW{head_i[SAMPLE_W-1]}}, head_i};
    end
    dev_q <= dev_d;
    // |N*v-S| < 2^(DW-1), so the square fits SQW bits
    sq_q  <= sq_full[SQW-1:0];
    if (ctrl_i.clr) begin
      spread_q <= '0;
      max_q    <= '0;
    end else if (dv2_q) begin
      spread_q <= spread_q + {{CW{1'b0}}, sq_q};
      if (sq_q > max_q) begin
        max_q <= sq_q;
      end
    end
  end

  assign spread_o = spread_q;
  assign max_sq_o = max_q;

endmodule

FILE: dv/sliding_window_outlier_detector_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_outlier_detector_core: stream stimulus,
// threshold writes, and a scoreboard that predicts each window verdict and position.
// Depends on swod_pkg and the core RTL.
module sliding_window_outlier_detector_core_test;

  localparam int unsigned WIN    = 3;
  localparam int unsigned SETTLE = 2 * WIN + 14;  // cycles after the last result before idle

  typedef struct {
    logic        anomaly;
    logic [15:0] start_pos;
  } window_verdict_t;

  class outlier_scoreboard;
    logic signed [15:0] history[WIN-1];
    int unsigned        filled;
    logic [15:0]        next_pos;
    logic [7:0]         threshold;
    window_verdict_t    pending_verdicts[$];
    int unsigned        mismatches;

    function new();
      foreach (history[i]) history[i] = '0;
      filled     = 0;
      next_pos   = '0;
      threshold  = swod_pkg::TH_RESET;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [7:0] th);
      threshold = th;
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    // accepted sample: update the window and queue the verdict it completes, if any
    function void take_sample(logic signed [15:0] smp, logic restart);
      longint          vals[WIN];
      longint          total, d;
      longint unsigned devsq[WIN];
      longint unsigned spread, bound;
      logic            flag;
      window_verdict_t v;
      if (restart) begin
        foreach (history[i]) history[i] = '0;
        filled   = 0;
        next_pos = '0;
      end
      if (filled < WIN - 1) begin
        history[filled] = smp;
        filled++;
        return;
      end
      for (int i = 0; i < WIN - 1; i++) vals[i] = longint'(history[i]);
      vals[WIN-1] = longint'(smp);
      total = 0;
      foreach (vals[i]) total += vals[i];
      spread = 0;
      foreach (vals[i]) begin
        d = longint'(WIN) * vals[i] - total;
        if (d < 0) d = -d;
        devsq[i] = longint'(d) * d;
        spread += devsq[i];
      end
      bound = longint'(threshold) * threshold * spread;
      flag  = 1'b0;
      foreach (devsq[i])
        if (devsq[i] * WIN * 256 > bound) flag = 1'b1;
      for (int i = 0; i + 1 < WIN - 1; i++) history[i] = history[i+1];
      history[WIN-2] = smp;
      v.anomaly   = flag;
      v.start_pos = next_pos;
      pending_verdicts.push_back(v);
      next_pos++;
    endfunction

    task check_window(logic anomaly, logic [15:0] start_pos);
      window_verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("unexpected result anomaly=%0d start=%0d", anomaly, start_pos));
        return;
      end
      v = pending_verdicts.pop_front();
      if (anomaly !== v.anomaly)
        report($sformatf("window %0d: anomaly %0d, want %0d", v.start_pos, anomaly,
                         v.anomaly));
      if (start_pos !== v.start_pos)
        report($sformatf("window_start %0d, want %0d", start_pos, v.start_pos));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] sample
  logic [0:0]  s_axis_tuser = '0;   // [0] series_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] window_start
  logic [0:0]  m_axis_tuser;        // [0] anomaly
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  logic               idle_on = 1'b1;
  outlier_scoreboard  sb = new();

  sliding_window_outlier_detector_core #(.WINDOW(WIN)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver backpressure and result check
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_window(m_axis_tuser[0], m_axis_tdata);
    m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 12) : 1'b1;
  end

  // tvalid stays high after a transaction; it only drops on a gap or in settle_idle
  task automatic send_sample(logic [15:0] smp, logic restart);
    while (idle_on && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_sample(smp, restart);
  endtask

  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [7:0] th);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= th;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_threshold(th);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned count, logic [7:0] th);
    logic [15:0] smp, base;
    int unsigned kind, jitter;
    settle_idle();
    write_threshold(th);
    base = 16'($urandom);
    jitter = 0;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if (n % 16 == 0) begin
        case ($urandom_range(0, 3))
          0: jitter = 0;
          1: jitter = 3;
          2: jitter = 64;
          default: jitter = 2048;
        endcase
      end
      if (kind < 10) begin
        smp = 16'($urandom);
      end else if (kind < 18) begin
        case ($urandom_range(0, 3))
          0: smp = 16'h8000;
          1: smp = 16'h7fff;
          2: smp = 16'h0000;
          default: smp = 16'hffff;
        endcase
      end else begin
        smp = base + 16'($urandom_range(0, jitter)) - 16'(jitter / 2);
      end
      if ($urandom_range(0, 99) < 4) begin
        base = 16'($urandom);
        send_sample(smp, 1'b1);
      end else begin
        send_sample(smp, 1'b0);
      end
    end
  endtask

  initial begin
    logic [15:0] base;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold 2.0: a window of three can never exceed it
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    // restart mid-series, then an all-equal window
    send_sample(16'd100, 1'b1);
    send_sample(16'd100, 1'b0);
    send_sample(16'd100, 1'b0);
    settle_idle();
    // zero threshold: any deviation flags, equal samples do not
    write_threshold(8'd0);
    send_sample(16'd100, 1'b0);
    send_sample(16'd101, 1'b0);
    send_sample(16'd5, 1'b1);
    send_sample(16'd5, 1'b0);
    send_sample(-16'sd5, 1'b0);
    settle_idle();
    // 22 is the largest threshold a lone outlier of three still exceeds
    write_threshold(8'd22);
    send_sample(16'd0, 1'b1);
    send_sample(16'd0, 1'b0);
    send_sample(16'd256, 1'b0);
    settle_idle();
    write_threshold(8'd23);
    send_sample(16'd0, 1'b0);
    send_sample(16'd256, 1'b0);
    settle_idle();
    write_threshold(8'd255);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h0000, 1'b0);

    // long run without idling on either side
    settle_idle();
    write_threshold(8'd20);
    idle_on <= 1'b0;
    base = 16'($urandom);
    send_sample(base, 1'b1);
    for (int n = 0; n < 49; n++)
      send_sample(base + 16'($urandom_range(0, 15)), 1'b0);
    settle_idle();
    idle_on <= 1'b1;

    random_phase(60, 8'($urandom_range(0, 30)));
    random_phase(50, 8'd0);
    random_phase(50, 8'd22);
    random_phase(60, 8'($urandom_range(0, 24)));
    random_phase(40, 8'd255);
    random_phase(40, swod_pkg::TH_RESET);
    random_phase(30, 8'($urandom_range(8, 22)));
    settle_idle();

    if (sb.mismatches == 0) begin
      $display("sliding_window_outlier_detector_core_test: clean");
    end else begin
      $display("sliding_window_outlier_detector_core_test: errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("sliding_window_outlier_detector_core_test: errors");
    $finish;
  end

endmodule
